// ----- hw/rtl/stsi_pkg.sv -----
// Shared types, sizes and status codes of the symbol table search/insert block.
package stsi_pkg;

  localparam int TABLE_SIZE  = 128;
  localparam int NAME_CHARS  = 128;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
  localparam int POS_W       = $clog2(NAME_CHARS);
  localparam int NS_AW       = IDX_W + POS_W;
  localparam int NS_DEPTH    = 1 << NS_AW;
  localparam int SLOT_W      = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic {
    MODE_SEARCH = 1'b0,
    MODE_INSERT = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  name_char;
    logic        last_char;
    logic [15:0] entry_address;
    logic        entry_type;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [15:0]       found_address;
    logic              found_type;
  } out_item_t;

  // Classified character beat, as passed from front to back
  typedef struct packed {
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    logic             ovf;
    logic             last;
    logic             mode;
    logic [15:0]      addr;
    logic             etype;
  } queue_item_t;

endpackage

// ----- hw/rtl/stsi_front.sv -----
// Front end: takes character beats, tracks position and overflow, classifies each beat.
module stsi_front
  import stsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        push_valid,
  input  logic        push_ready,
  output queue_item_t push_item
);

  logic [POS_W-1:0] pos;
  logic             ovf;
  logic             eff_ovf;
  logic             accept;

  // name may hold at most NAME_CHARS-1 characters
  assign eff_ovf    = ovf || (pos >= POS_W'(NAME_CHARS - 1));
  assign in_stall   = !push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_item.ch    = in_data.name_char;
    push_item.pos   = pos;
    push_item.ovf   = eff_ovf;
    push_item.last  = in_data.last_char;
    push_item.mode  = in_data.mode;
    push_item.addr  = in_data.entry_address;
    push_item.etype = in_data.entry_type;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (in_data.last_char) begin
        pos <= '0;
        ovf <= 1'b0;
      end else if (eff_ovf) begin
        ovf <= 1'b1;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/stsi_queue.sv -----
// Short FIFO between front and back ends.
module stsi_queue
  import stsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  queue_item_t push_item,
  output logic        pop_valid,
  input  logic        pop,
  output queue_item_t pop_item
);

  queue_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      fill <= fill + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/stsi_back.sv -----
// Back end: sweeps stored entries per character, resolves the name, owns the stores.
module stsi_back
  import stsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  queue_item_t q_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_RESULT} state_t;

  state_t            state;
  queue_item_t       cur;
  logic [CNT_W-1:0]  count;
  logic [TABLE_SIZE-1:0] match;
  logic [IDX_W-1:0]  issue_idx;
  logic              issue_on;
  logic              issue_last;
  logic              rd_v;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_last;
  logic              hit;
  logic [IDX_W-1:0]  hit_slot;
  logic [15:0]       hit_addr;
  logic              hit_type;

  // stores
  logic [7:0]        name_store    [NS_DEPTH];
  logic [POS_W-1:0]  name_length   [TABLE_SIZE];
  logic [15:0]       address_store [TABLE_SIZE];
  logic              type_store    [TABLE_SIZE];
  logic [7:0]        ns_rd;
  logic [POS_W-1:0]  len_rd;
  logic [15:0]       addr_rd;
  logic              type_rd;

  logic              room;
  logic              out_free;
  logic              stage_we;
  logic              ins_we;
  logic              m_next;
  logic [POS_W-1:0]  len_now;
  out_item_t         res;

  assign room       = (count < CNT_W'(TABLE_SIZE));
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign issue_last = (CNT_W'(issue_idx) + CNT_W'(1)) == count;
  assign len_now    = cur.pos + POS_W'(1);
  assign stage_we   = q_pop && !q_item.ovf && room;
  assign ins_we     = (state == S_RESULT) && out_free && !cur.ovf &&
                      (cur.mode == MODE_INSERT) && room && !hit;

  // match survives this character: entry long enough and same character
  assign m_next = match[rd_idx] && (len_rd > cur.pos) && (ns_rd == cur.ch);

  // characters are staged into the free slot as they arrive
  always_ff @(posedge clk) begin
    if (stage_we) begin
      name_store[{count[IDX_W-1:0], q_item.pos}] <= q_item.ch;
    end
    if (issue_on) begin
      ns_rd <= name_store[{issue_idx, cur.pos}];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      name_length[count[IDX_W-1:0]]   <= len_now;
      address_store[count[IDX_W-1:0]] <= cur.addr;
      type_store[count[IDX_W-1:0]]    <= cur.etype;
    end
    if (issue_on) begin
      len_rd  <= name_length[issue_idx];
      addr_rd <= address_store[issue_idx];
      type_rd <= type_store[issue_idx];
    end
  end

  always_comb begin
    res.status        = ST_OK;
    res.slot_index    = '0;
    res.found_address = '0;
    res.found_type    = 1'b0;
    if (cur.ovf) begin
      res.status = ST_TOO_LONG;
    end else if (cur.mode == MODE_SEARCH) begin
      if (hit) begin
        res.slot_index    = SLOT_W'(hit_slot);
        res.found_address = hit_addr;
        res.found_type    = hit_type;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (!room) begin
      res.status = ST_FULL;
    end else if (hit) begin
      res.status     = ST_DUPLICATE;
      res.slot_index = SLOT_W'(hit_slot);
    end else begin
      res.slot_index = SLOT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      match     <= '1;
      issue_on  <= 1'b0;
      issue_idx <= '0;
      rd_v      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v    <= issue_on;
      rd_idx  <= issue_idx;
      rd_last <= issue_last;
      // output register: loads a new result when free, else clears once taken
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            hit <= 1'b0;
            if (q_item.ovf || count == '0) begin
              if (q_item.last) begin
                state <= S_RESULT;
              end
            end else begin
              state     <= S_SWEEP;
              issue_idx <= '0;
              issue_on  <= 1'b1;
            end
          end
        end
        S_SWEEP: begin
          if (issue_on) begin
            if (issue_last) begin
              issue_on <= 1'b0;
            end else begin
              issue_idx <= issue_idx + IDX_W'(1);
            end
          end
          if (rd_v) begin
            match[rd_idx] <= m_next;
            // later entries overwrite, so the newest match wins
            if (cur.last && m_next && len_rd == len_now) begin
              hit      <= 1'b1;
              hit_slot <= rd_idx;
              hit_addr <= addr_rd;
              hit_type <= type_rd;
            end
            if (rd_last) begin
              state <= cur.last ? S_RESULT : S_IDLE;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_data  <= res;
            match     <= '1;
            if (ins_we) begin
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_SIZE))
    else $error("entry count beyond table size");

  a_count_on_result: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == S_RESULT))
    else $error("entry count moved outside result step");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && out_valid && out_stall) |=> (state == S_RESULT))
    else $error("result left while output register held");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (CNT_W'(rd_idx) < count))
    else $error("sweep read past stored entries");

endmodule

// ----- hw/rtl/symbol_table_search_insert_top.sv -----
// Top level of the symbol table search/insert block.
// Usage:
//   Input channel (in_valid / in_stall / in_data): one beat per identifier
//   character, in order; last_char marks the final one. mode, entry_address
//   and entry_type are taken from the final beat.
//   Output channel (out_valid / out_stall / out_data): one beat per final
//   character, giving status, slot index and, on a search hit, the stored
//   address and type.
//   The front end numbers the characters and flags over-long names; a
//   two-beat queue decouples it from the back end, which compares each
//   character against every stored entry one entry per cycle through a
//   single read port on the character store.
//   The back end takes a character from the queue only when idle and
//   sweeps every stored entry for it before taking the next (no sweep
//   when the table is empty or the name is already too long); a final
//   beat then passes through the result step into the output register.
//   Reset (rst, synchronous): empties the table and the queue and drops any
//   pending result. The stores need no clearing pass.
//   While out_stall is high the result beat holds; the back end waits with
//   its next result, and the queue keeps taking beats until it is full.
module symbol_table_search_insert_top
  import stsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        push_valid;
  logic        push_ready;
  queue_item_t push_item;
  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  stsi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples character intake from the entry sweep
  stsi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  stsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/symbol_table_search_insert_top_tb.sv -----
// Self-checking testbench for the symbol table search/insert block.
module symbol_table_search_insert_top_tb;
  import stsi_pkg::*;

  // Longest name the stimulus builds: two characters past the overflow point
  localparam int MAX_NAME    = NAME_CHARS + 2;
  localparam int POOL_SIZE   = 32;
  localparam int HOLD_CYCLES = 400;
  // The limit is several times both the back end's sweep of a full table for one
  // character beat and the long receiver hold-off
  localparam int QUIET_LIMIT = 20 * TABLE_SIZE + 4 * HOLD_CYCLES;

  // Shadow copy of the table: works out the result of every identifier and
  // checks the result beats against it in order.
  class symbol_table_scoreboard;
    logic [7:0]  stored_chars [TABLE_SIZE][NAME_CHARS];
    int unsigned stored_len   [TABLE_SIZE];
    logic [15:0] stored_addr  [TABLE_SIZE];
    logic        stored_type  [TABLE_SIZE];
    int unsigned entries;
    logic [7:0]  name_so_far  [NAME_CHARS];
    int unsigned chars_taken;
    bit          too_long;
    out_item_t   awaited [$];
    int unsigned mismatches;
    int unsigned status_seen [5];

    function void note_beat(in_item_t beat);
      out_item_t want;
      int        hit_slot;
      bit        equal;
      // one character is kept back for the terminator
      if (!too_long && chars_taken >= NAME_CHARS - 1) too_long = 1'b1;
      if (!too_long) begin
        name_so_far[chars_taken] = beat.name_char;
        chars_taken++;
      end
      if (!beat.last_char) return;

      hit_slot = -1;
      if (!too_long) begin
        for (int i = 0; i < entries; i++) begin
          equal = (stored_len[i] == chars_taken);
          for (int p = 0; equal && p < chars_taken; p++)
            equal = (stored_chars[i][p] == name_so_far[p]);
          if (equal) hit_slot = i;
        end
      end

      want        = '0;
      want.status = ST_OK;
      if (too_long) begin
        want.status = ST_TOO_LONG;
      end else if (beat.mode == MODE_SEARCH) begin
        if (hit_slot < 0) begin
          want.status = ST_NOT_FOUND;
        end else begin
          want.slot_index    = SLOT_W'(hit_slot);
          want.found_address = stored_addr[hit_slot];
          want.found_type    = stored_type[hit_slot];
        end
      end else if (entries >= TABLE_SIZE) begin
        want.status = ST_FULL;
      end else if (hit_slot >= 0) begin
        want.status     = ST_DUPLICATE;
        want.slot_index = SLOT_W'(hit_slot);
      end else begin
        for (int p = 0; p < chars_taken; p++) stored_chars[entries][p] = name_so_far[p];
        stored_len[entries]  = chars_taken;
        stored_addr[entries] = beat.entry_address;
        stored_type[entries] = beat.entry_type;
        want.slot_index      = SLOT_W'(entries);
        entries++;
      end
      awaited.push_back(want);
      chars_taken = 0;
      too_long    = 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with none expected: status %0d slot %0d address %h type %0d",
                 $time, got.status, got.slot_index, got.found_address, got.found_type);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      status_seen[int'(want.status)]++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index expected %0d, got %0d", $time, want.slot_index,
                 got.slot_index);
        mismatches++;
      end
      if (got.found_address !== want.found_address) begin
        $display("%0t: found_address expected %h, got %h", $time, want.found_address,
                 got.found_address);
        mismatches++;
      end
      if (got.found_type !== want.found_type) begin
        $display("%0t: found_type expected %0d, got %0d", $time, want.found_type,
                 got.found_type);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;

  symbol_table_scoreboard sb;

  // Idle rates in percent, changed between phases
  int send_idle_pct  = 20;
  int recv_stall_pct = 80;
  bit hold_req       = 1'b0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  // Identifier under construction, and a pool of earlier ones for reuse
  logic [7:0] name_buf   [MAX_NAME];
  int         name_len;
  logic [7:0] pool_chars [POOL_SIZE][MAX_NAME];
  int         pool_len   [POOL_SIZE];
  int         pool_fill  = 0;

  symbol_table_search_insert_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Beat monitor: both channels sampled at the rising edge, before the block's
  // registers move, so the sampled values are those the edge acts on.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
               QUIET_LIMIT, sb.awaited.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall at the current rate; on request, one long hold-off
  // counted here so the sender keeps offering beats meanwhile.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Half the characters from a small alphabet so that names collide often
  function automatic logic [7:0] pick_char();
    if ($urandom_range(1)) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom_range(1, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends name_buf; mode, address and type only matter on the final beat, so
  // the earlier beats carry noise there.
  task automatic send_name(input mode_t op, input logic [15:0] addr, input logic etype);
    in_item_t beat;
    for (int k = 0; k < name_len; k++) begin
      beat.name_char = name_buf[k];
      beat.last_char = (k == name_len - 1);
      if (beat.last_char) begin
        beat.mode          = op;
        beat.entry_address = addr;
        beat.entry_type    = etype;
      end else begin
        beat.mode          = 1'($urandom_range(1));
        beat.entry_address = 16'($urandom);
        beat.entry_type    = 1'($urandom_range(1));
      end
      send_beat(beat);
    end
  endtask

  // Directed names of up to four characters, given as a right-aligned literal
  task automatic send_literal(input mode_t op, input logic [31:0] chars, input int n,
                              input logic [15:0] addr, input logic etype);
    name_len = n;
    for (int k = 0; k < n; k++) name_buf[k] = chars[8 * (n - 1 - k) +: 8];
    send_name(op, addr, etype);
  endtask

  task automatic add_to_pool();
    int slot;
    slot = (pool_fill < POOL_SIZE) ? pool_fill : $urandom_range(POOL_SIZE - 1);
    if (pool_fill < POOL_SIZE) pool_fill++;
    pool_len[slot] = name_len;
    for (int k = 0; k < name_len; k++) pool_chars[slot][k] = name_buf[k];
  endtask

  // Mostly short names; reuse of earlier names gives hits and duplicates, and
  // the small edits give near misses (prefixes, extensions, one char off).
  task automatic pick_name();
    int roll;
    int pick;
    roll = $urandom_range(99);
    if (roll < 1) begin
      name_len = $urandom_range(NAME_CHARS - 3, NAME_CHARS + 1);
      for (int k = 0; k < name_len; k++) name_buf[k] = pick_char();
      add_to_pool();
    end else if (roll < 45 && pool_fill > 0) begin
      pick     = $urandom_range(pool_fill - 1);
      name_len = pool_len[pick];
      for (int k = 0; k < name_len; k++) name_buf[k] = pool_chars[pick][k];
      case ($urandom_range(7))
        0: begin
          if (name_len > 1) name_len--;
        end
        1: begin
          if (name_len < MAX_NAME) begin
            name_buf[name_len] = pick_char();
            name_len++;
          end
        end
        2: begin
          name_buf[$urandom_range(name_len - 1)] = pick_char();
        end
        default: ;
      endcase
    end else begin
      name_len = $urandom_range(1, 6);
      for (int k = 0; k < name_len; k++) name_buf[k] = pick_char();
      add_to_pool();
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick_name();
      send_name(($urandom_range(99) < 55) ? MODE_INSERT : MODE_SEARCH, 16'($urandom),
                1'($urandom_range(1)));
    end
  endtask

  // Sender pause: input idle until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.awaited.size() != 0);
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, hits, misses, duplicates, prefixes, char extremes
    send_literal(MODE_SEARCH, "a", 1, 16'h0000, 1'b0);
    send_literal(MODE_INSERT, "a", 1, 16'hFFFF, 1'b1);
    send_literal(MODE_INSERT, 32'h01FF, 2, 16'h0000, 1'b0);
    send_literal(MODE_SEARCH, "a", 1, 16'h0000, 1'b0);
    send_literal(MODE_SEARCH, 32'h01FF, 2, 16'hFFFF, 1'b1);
    send_literal(MODE_INSERT, "a", 1, 16'h1234, 1'b0);
    send_literal(MODE_SEARCH, "ab", 2, 16'h0000, 1'b0);
    send_literal(MODE_INSERT, "ab", 2, 16'h5A5A, 1'b0);
    send_literal(MODE_SEARCH, 32'h01, 1, 16'h0000, 1'b0);
    send_literal(MODE_SEARCH, 32'h807F, 2, 16'h0000, 1'b0);
    send_literal(MODE_INSERT, 32'h807F55AA, 4, 16'hA5A5, 1'b1);
    send_literal(MODE_SEARCH, "ab", 2, 16'h0000, 1'b0);

    // Name length boundary while the table is small: longest legal name stored
    // and found, one character more rejected for search and insert alike
    name_len = NAME_CHARS - 1;
    for (int k = 0; k < name_len; k++) name_buf[k] = 8'($urandom_range(1, 255));
    add_to_pool();
    send_name(MODE_INSERT, 16'($urandom), 1'b1);
    send_name(MODE_SEARCH, 16'($urandom), 1'b0);
    name_buf[name_len] = pick_char();
    name_len++;
    send_name(MODE_SEARCH, 16'($urandom), 1'b0);
    send_name(MODE_INSERT, 16'($urandom), 1'b1);

    // Phase one: sender idles a little, receiver a lot; one long hold-off part way
    run_random(300);
    hold_req = 1'b1;
    run_random(300);
    wait_drained();

    // Phase two: the other way round
    send_idle_pct  = 80;
    recv_stall_pct = 20;
    run_random(500);
    wait_drained();

    // Phase three: no idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(350);

    // Fill whatever room is left, then the full-table cases
    while (sb.entries < TABLE_SIZE) begin
      name_len = 3;
      for (int k = 0; k < name_len; k++) name_buf[k] = 8'($urandom_range(1, 255));
      send_name(MODE_INSERT, 16'($urandom), 1'($urandom_range(1)));
    end
    name_len = 4;
    for (int k = 0; k < name_len; k++) name_buf[k] = 8'($urandom_range(1, 255));
    send_name(MODE_INSERT, 16'($urandom), 1'b1);
    // stored name again: full outranks duplicate; then found in the top slot
    name_len = sb.stored_len[TABLE_SIZE - 1];
    for (int k = 0; k < name_len; k++) name_buf[k] = sb.stored_chars[TABLE_SIZE - 1][k];
    send_name(MODE_INSERT, 16'($urandom), 1'b0);
    send_name(MODE_SEARCH, 16'($urandom), 1'b0);
    // too long outranks full
    name_len = NAME_CHARS + 1;
    for (int k = 0; k < name_len; k++) name_buf[k] = pick_char();
    send_name(MODE_INSERT, 16'($urandom), 1'b1);

    // Drain, then allow for a stray late beat
    wait_drained();
    repeat (2 * TABLE_SIZE + 16) @(negedge clk);

    $display("Ran %0d character beats: %0d ok, %0d not found, %0d duplicate, %0d full,",
             items_sent, sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_DUPLICATE], sb.status_seen[ST_FULL]);
    $display("%0d too long; table ended with %0d entries, %0d mismatches.",
             sb.status_seen[ST_TOO_LONG], sb.entries, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/stsi_pkg.sv
hw/rtl/stsi_front.sv
hw/rtl/stsi_queue.sv
hw/rtl/stsi_back.sv
hw/rtl/symbol_table_search_insert_top.sv
tb/symbol_table_search_insert_top_tb.sv
